// File: src/route_table_aging_broadcast_defines.svh
// ----------------------------------------------------------------------------
// Route table assertion macros
// Shared property forms for the route table aging and broadcast block.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_AGING_BROADCAST_DEFINES_SVH
`define ROUTE_TABLE_AGING_BROADCAST_DEFINES_SVH

// same-cycle implication
`define RTAB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTAB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rtab_pkg.sv
// ----------------------------------------------------------------------------
// Route table package
// Entry type, command and result codes, register map and helper functions.
// ----------------------------------------------------------------------------
package rtab_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_RECORD = 2'd0,
		KIND_SEND   = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	localparam logic [1:0] TYPE_NOPATH = 2'd0;
	localparam logic [1:0] TYPE_DIRECT = 2'd1;
	localparam logic [1:0] TYPE_BRIDGE = 2'd2;

	localparam logic [2:0] CFG_BRIDGING_DISABLED = 3'd0;
	localparam logic [2:0] CFG_HIGH_COST         = 3'd1;
	localparam logic [2:0] CFG_CHECK_INTERVAL    = 3'd2;
	localparam logic [2:0] CFG_AGE_PERIOD        = 3'd3;
	localparam logic [2:0] CFG_BROADCAST_PERIOD  = 3'd4;

	localparam logic [15:0] HIGH_COST_RST        = 16'd1024;
	localparam logic [15:0] CHECK_INTERVAL_RST   = 16'd500;
	localparam logic [19:0] AGE_PERIOD_RST       = 20'd4000;
	localparam logic [19:0] BROADCAST_PERIOD_RST = 20'd15000;

	typedef struct packed {
		logic [1:0]  rtype;
		logic [15:0] cost;
		logic [3:0]  port;
	} entry_t;

	localparam entry_t ENTRY_RST = '{rtype: TYPE_NOPATH, cost: 16'd0, port: 4'd0};

	typedef struct packed {
		logic hit;
		logic age_due;
		logic bc_due;
	} tmr_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK_EVAL,
		ST_AGE,
		ST_CNT,
		ST_CNT_END,
		ST_REC_RD,
		ST_REC_EV,
		ST_SND_RD,
		ST_SND_EV,
		ST_RD_OUT
	} state_t;

	function automatic logic entry_usable(input entry_t e, input logic [15:0] hc);
		return (e.cost < hc) && (e.rtype != TYPE_NOPATH);
	endfunction

	function automatic logic entry_direct(input entry_t e, input logic [15:0] hc);
		return (e.cost < hc) && (e.rtype == TYPE_DIRECT);
	endfunction

	function automatic entry_t entry_aged(input entry_t e, input logic [15:0] hc);
		entry_t r;
		r = e;
		if ((e.rtype == TYPE_DIRECT || e.rtype == TYPE_BRIDGE) && e.cost < hc) begin
			r.cost = e.cost + 16'd1;
		end
		return r;
	endfunction

endpackage

// File: src/rtab_mem.sv
// ----------------------------------------------------------------------------
// Route table memory
// One write and one registered read per cycle; per-entry valid bits give the
// no-path reset value for entries never written.
// ----------------------------------------------------------------------------
module rtab_mem #(
	parameter int SUBNETS = 16,
	parameter int AW      = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output rtab_pkg::entry_t rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  rtab_pkg::entry_t wr_data
);
	import rtab_pkg::*;

	entry_t             mem_q [SUBNETS];
	logic [SUBNETS-1:0] valid_q;
	entry_t             rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem_q[rd_addr] : ENTRY_RST;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/rtab_timer.sv
// ----------------------------------------------------------------------------
// Route table tick timer
// Tick clock and the check, aging and broadcast deadlines with wrap-aware
// due tests.
// ----------------------------------------------------------------------------
module rtab_timer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                eval,
	input  logic [15:0]         check_interval,
	input  logic [19:0]         age_period,
	input  logic [19:0]         broadcast_period,
	output rtab_pkg::tmr_stat_t stat
);
	import rtab_pkg::*;

	logic [31:0] clock_now_q;
	logic [31:0] next_check_q;
	logic [31:0] next_age_q;
	logic [31:0] next_bc_q;
	logic [31:0] age_diff;
	logic [31:0] bc_diff;

	assign age_diff     = next_age_q - clock_now_q;
	assign bc_diff      = next_bc_q - clock_now_q;
	assign stat.hit     = clock_now_q == next_check_q;
	assign stat.age_due = age_diff[31];
	assign stat.bc_due  = bc_diff[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_now_q  <= 32'd0;
			next_check_q <= 32'd1;
			next_age_q   <= 32'd1;
			next_bc_q    <= 32'd1;
		end else begin
			if (tick) begin
				clock_now_q <= clock_now_q + 32'd1;
			end
			if (eval && stat.hit) begin
				next_check_q <= next_check_q + 32'(check_interval);
				if (stat.age_due) begin
					next_age_q <= next_age_q + 32'(age_period);
				end
				if (stat.bc_due) begin
					next_bc_q <= next_bc_q + 32'(broadcast_period);
				end
			end
		end
	end

endmodule

// File: src/route_table_aging_broadcast.sv
// ----------------------------------------------------------------------------
// Route table with aging and bridge broadcast
// Top level: command sequencer, register file and output register.
// ----------------------------------------------------------------------------
// One item at a time; input is stalled until the sequencer is idle. A read
// waits for the output register to be free. A check tick runs an aging pass
// when aging is due and, when a broadcast is due and bridging is enabled, a
// usable-route count; when two or more usable direct routes are found, a
// record walk and a send walk follow, both held by output stalls. Every walk
// goes through the table memory's single read port. The table resets to no
// path through per-entry valid bits, so no clearing pass runs after reset.
`include "route_table_aging_broadcast_defines.svh"

module route_table_aging_broadcast #(
	parameter int SUBNETS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  entry_index,
	input  logic [1:0]  entry_type,
	input  logic [15:0] entry_cost,
	input  logic [3:0]  entry_port,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  subnet,
	output logic [15:0] cost,
	output logic [3:0]  port,
	output logic [1:0]  route_type,
	output logic [4:0]  record_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import rtab_pkg::*;

	localparam int AW = $clog2(SUBNETS);
	localparam int CW = $clog2(SUBNETS + 1);

	state_t      state_q, state_d;
	logic [CW-1:0] ptr_q, n_q, nd_q;
	logic        pend_s1;
	logic [AW-1:0] age_addr_s1;
	logic        bc_due_q;
	logic [3:0]  idx_q;
	logic        in_range_q;

	logic        bd_q;
	logic [15:0] high_cost_q;
	logic [15:0] check_interval_q;
	logic [19:0] age_period_q;
	logic [19:0] bc_period_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  subnet_q;
	logic [15:0] cost_q;
	logic [3:0]  port_q;
	logic [1:0]  rtype_q;
	logic [4:0]  count_q;
	logic        last_q;

	logic        in_acc, slot_free, ptr_end, in_range;
	logic        use_c, dir_c;
	entry_t      cur;
	tmr_stat_t   stat;
	logic        tick, eval;

	logic        mem_re, mem_we;
	logic [AW-1:0] mem_rd_addr, mem_wr_addr;
	entry_t      mem_wr_data;

	logic        out_load;
	logic [1:0]  od_kind;
	logic [3:0]  od_subnet;
	logic [15:0] od_cost;
	logic [3:0]  od_port;
	logic [1:0]  od_rtype;
	logic [4:0]  od_count;
	logic        od_last;

	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign ptr_end   = ptr_q == CW'(SUBNETS);
	assign in_range  = 32'(entry_index) < SUBNETS;
	assign use_c     = entry_usable(cur, high_cost_q);
	assign dir_c     = entry_direct(cur, high_cost_q);
	assign cfg_ready = 1'b1;

	rtab_mem #(.SUBNETS(SUBNETS), .AW(AW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_re),
		.rd_addr (mem_rd_addr),
		.rd_data (cur),
		.wr_en   (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	rtab_timer u_timer (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick             (tick),
		.eval             (eval),
		.check_interval   (check_interval_q),
		.age_period       (age_period_q),
		.broadcast_period (bc_period_q),
		.stat             (stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (cmd)
						CMD_TICK: state_d = ST_TICK_EVAL;
						CMD_READ: state_d = ST_RD_OUT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK_EVAL: begin
				if (!stat.hit) begin
					state_d = ST_IDLE;
				end else if (stat.age_due) begin
					state_d = ST_AGE;
				end else if (stat.bc_due && !bd_q) begin
					state_d = ST_CNT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_AGE: begin
				if (ptr_end && pend_s1) begin
					state_d = (bc_due_q && !bd_q) ? ST_CNT : ST_IDLE;
				end
			end
			ST_CNT: begin
				if (ptr_end && pend_s1) begin
					state_d = ST_CNT_END;
				end
			end
			ST_CNT_END: state_d = (nd_q > CW'(1)) ? ST_REC_RD : ST_IDLE;
			ST_REC_RD:  state_d = ptr_end ? ST_SND_RD : ST_REC_EV;
			ST_REC_EV: begin
				if (!use_c || slot_free) begin
					state_d = ST_REC_RD;
				end
			end
			ST_SND_RD:  state_d = ptr_end ? ST_IDLE : ST_SND_EV;
			ST_SND_EV: begin
				if (!dir_c || slot_free) begin
					state_d = ST_SND_RD;
				end
			end
			ST_RD_OUT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall    = state_q != ST_IDLE;
		tick        = 1'b0;
		eval        = 1'b0;
		mem_re      = 1'b0;
		mem_rd_addr = ptr_q[AW-1:0];
		mem_we      = 1'b0;
		mem_wr_addr = age_addr_s1;
		mem_wr_data = entry_aged(cur, high_cost_q);
		out_load    = 1'b0;
		od_kind     = KIND_RECORD;
		od_subnet   = 4'(ptr_q);
		od_cost     = cur.cost;
		od_port     = 4'd0;
		od_rtype    = TYPE_NOPATH;
		od_count    = 5'(n_q);
		od_last     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tick        = in_acc && cmd == CMD_TICK;
				mem_re      = in_acc && cmd == CMD_READ;
				mem_rd_addr = AW'(entry_index);
				mem_we      = in_acc && cmd == CMD_WRITE && in_range;
				mem_wr_addr = AW'(entry_index);
				mem_wr_data = '{rtype: entry_type, cost: entry_cost, port: entry_port};
			end
			ST_TICK_EVAL: eval = 1'b1;
			ST_AGE: begin
				mem_re = !ptr_end;
				mem_we = pend_s1;
			end
			ST_CNT:    mem_re = !ptr_end;
			ST_REC_RD: mem_re = !ptr_end;
			ST_SND_RD: mem_re = !ptr_end;
			ST_REC_EV: out_load = use_c && slot_free;
			ST_SND_EV: begin
				out_load = dir_c && slot_free;
				od_kind  = KIND_SEND;
				od_port  = cur.port;
				od_last  = nd_q == CW'(1);
			end
			ST_RD_OUT: begin
				out_load  = slot_free;
				od_kind   = KIND_READ;
				od_subnet = idx_q;
				od_cost   = in_range_q ? cur.cost : 16'd0;
				od_port   = in_range_q ? cur.port : 4'd0;
				od_rtype  = in_range_q ? cur.rtype : TYPE_NOPATH;
				od_count  = 5'd0;
				od_last   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= '0;
			pend_s1  <= 1'b0;
			n_q      <= '0;
			nd_q     <= '0;
			bc_due_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_TICK_EVAL: begin
					ptr_q    <= '0;
					pend_s1  <= 1'b0;
					n_q      <= '0;
					nd_q     <= '0;
					bc_due_q <= stat.bc_due;
				end
				ST_AGE, ST_CNT: begin
					if (state_q == ST_CNT && pend_s1 && use_c) begin
						n_q <= n_q + CW'(1);
						if (dir_c) begin
							nd_q <= nd_q + CW'(1);
						end
					end
					if (ptr_end && pend_s1) begin
						ptr_q   <= '0;
						pend_s1 <= 1'b0;
					end else begin
						if (!ptr_end) begin
							ptr_q <= ptr_q + CW'(1);
						end
						pend_s1 <= !ptr_end;
					end
				end
				ST_CNT_END: ptr_q <= '0;
				ST_REC_RD: begin
					if (ptr_end) begin
						ptr_q <= '0;
					end
				end
				ST_REC_EV: begin
					if (!use_c || slot_free) begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				ST_SND_EV: begin
					if (!dir_c || slot_free) begin
						ptr_q <= ptr_q + CW'(1);
						if (dir_c) begin
							nd_q <= nd_q - CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		age_addr_s1 <= ptr_q[AW-1:0];
		if (in_acc) begin
			idx_q      <= entry_index;
			in_range_q <= in_range;
		end
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bd_q             <= 1'b0;
			high_cost_q      <= HIGH_COST_RST;
			check_interval_q <= CHECK_INTERVAL_RST;
			age_period_q     <= AGE_PERIOD_RST;
			bc_period_q      <= BROADCAST_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BRIDGING_DISABLED: bd_q             <= cfg_data[0];
				CFG_HIGH_COST:         high_cost_q      <= cfg_data[15:0];
				CFG_CHECK_INTERVAL:    check_interval_q <= cfg_data[15:0];
				CFG_AGE_PERIOD:        age_period_q     <= cfg_data;
				CFG_BROADCAST_PERIOD:  bc_period_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q   <= od_kind;
			subnet_q <= od_subnet;
			cost_q   <= od_cost;
			port_q   <= od_port;
			rtype_q  <= od_rtype;
			count_q  <= od_count;
			last_q   <= od_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign subnet       = subnet_q;
	assign cost         = cost_q;
	assign port         = port_q;
	assign route_type   = rtype_q;
	assign record_count = count_q;
	assign last         = last_q;

	`RTAB_ASSERT_IMP(a_out_slot, out_load, slot_free, "beat loaded over a waiting beat")
	`RTAB_ASSERT_IMP(a_wr_state, mem_we, (state_q == ST_IDLE || state_q == ST_AGE),
		"table write outside write or aging")
	`RTAB_ASSERT_IMP(a_age_overlap, mem_we && mem_re, mem_wr_addr != mem_rd_addr,
		"read and write-back hit the same entry")
	`RTAB_ASSERT_IMP(a_bc_direct, state_q == ST_REC_RD, nd_q > CW'(1),
		"broadcast without two usable direct routes")
	`RTAB_ASSERT_NXT(a_tick_eval, tick, state_q == ST_TICK_EVAL, "tick not evaluated")

endmodule
